@@ hw/rtl/spq_pkg.sv @@
// Package for the strict-priority three-level queue.
// Holds the command and status codes, default parameters and the result bundle.
// No dependencies.
`default_nettype none

package spq_pkg;

    // Number of priority levels and fixed port widths.
    localparam int LEVELS      = 3;
    localparam int LEVEL_BITS  = 2;
    localparam int VALUE_BITS  = 16;

    // Default parameter values for the top level.
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int DATA_BITS_DEF   = 16;

    // Command codes.
    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    // Status codes reported with each result.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_OVER  = 2'd1,
        STAT_UNDER = 2'd2
    } t_status;

    // Result bundle registered by the controller in the cycle after a beat.
    typedef struct packed {
        logic                  valid;
        logic                  pop_hit;
        logic [LEVEL_BITS-1:0] level;
        t_status               status;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/strict_priority_three_queue.sv @@
// Strict-priority three-level queue: push to a level, pop from the lowest-numbered non-empty level.
// The result strobe follows in the cycle after the start beat.
// Throughput: one beat per cycle; busy stays low, as the single memory has a write
// and a read port and each beat touches at most one of them.
// Reset clears pointers and counts; the data memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module strict_priority_three_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_BITS   = spq_pkg::DATA_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_cmd,
    input  wire logic [spq_pkg::LEVEL_BITS-1:0]       i_level,
    input  wire logic [spq_pkg::VALUE_BITS-1:0]       i_value,
    output logic                                      o_valid,
    output logic [spq_pkg::VALUE_BITS-1:0]            o_data_out,
    output logic [spq_pkg::LEVEL_BITS-1:0]            o_served_level,
    output logic [1:0]                                o_status
);

    localparam int SLOT_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ADDR_BITS = spq_pkg::LEVEL_BITS + SLOT_BITS;
    localparam int WORD_BITS = (DATA_BITS < spq_pkg::VALUE_BITS) ? DATA_BITS
                                                                 : spq_pkg::VALUE_BITS;

    logic                 beat;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    spq_pkg::t_result     result;

    // Every cycle can take a beat.
    assign busy = 1'b0;
    assign beat = start && !busy;

    spq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORD_BITS   (WORD_BITS),
        .SLOT_BITS   (SLOT_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (beat),
        .i_cmd     (i_cmd),
        .i_level   (i_level),
        .i_word    (i_value[WORD_BITS-1:0]),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_result  (result)
    );

    spq_store #(
        .ADDR_BITS (ADDR_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Popped data only shows on a successful pop; pushes and errors report zero.
    assign o_valid        = result.valid;
    assign o_data_out     = result.pop_hit ? spq_pkg::VALUE_BITS'(rd_data) : '0;
    assign o_served_level = result.level;
    assign o_status       = result.status;

endmodule

`default_nettype wire

@@ hw/rtl/spq_store.sv @@
// Data memory shared by the three queues, one region per level.
// Synchronous write, registered synchronous read. Depends on nothing.
`default_nettype none

module spq_store #(
    parameter int ADDR_BITS = 5,
    parameter int WORD_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [WORD_BITS-1:0] i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output logic      [WORD_BITS-1:0] o_rd_data
);

    localparam int WORDS = 1 << ADDR_BITS;

    logic [WORD_BITS-1:0] r_mem [0:WORDS-1];
    logic [WORD_BITS-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/spq_ctrl.sv @@
// Queue controller: head pointers, fill counts, priority pick and memory addressing.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int WORD_BITS   = spq_pkg::DATA_BITS_DEF,
    parameter int SLOT_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_beat,
    input  wire logic                              i_cmd,
    input  wire logic [spq_pkg::LEVEL_BITS-1:0]    i_level,
    input  wire logic [WORD_BITS-1:0]              i_word,
    output logic                                   o_wr_en,
    output logic [spq_pkg::LEVEL_BITS+SLOT_BITS-1:0] o_wr_addr,
    output logic [WORD_BITS-1:0]                   o_wr_data,
    output logic                                   o_rd_en,
    output logic [spq_pkg::LEVEL_BITS+SLOT_BITS-1:0] o_rd_addr,
    output spq_pkg::t_result                       o_result
);

    localparam int LEVELS     = spq_pkg::LEVELS;
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [SLOT_BITS-1:0]  r_head  [0:LEVELS-1];
    logic [COUNT_BITS-1:0] r_count [0:LEVELS-1];
    logic [SLOT_BITS-1:0]  n_head  [0:LEVELS-1];
    logic [COUNT_BITS-1:0] n_count [0:LEVELS-1];
    spq_pkg::t_result      r_result;
    spq_pkg::t_result      n_result;

    logic                           is_push;
    logic                           level_ok;
    logic                           push_ok;
    logic                           pop_found;
    logic [spq_pkg::LEVEL_BITS-1:0] pop_level;
    logic [SLOT_BITS:0]             tail_sum;
    logic [SLOT_BITS-1:0]           tail_slot;
    logic [SLOT_BITS-1:0]           pop_head;
    logic [SLOT_BITS-1:0]           pop_head_next;

    // Push checks: the level must exist and its queue must have room.
    always_comb begin
        is_push  = (i_cmd == spq_pkg::CMD_PUSH);
        level_ok = (i_level < spq_pkg::LEVEL_BITS'(LEVELS));
        push_ok  = is_push && level_ok
                   && (r_count[i_level] != COUNT_BITS'(QUEUE_DEPTH));
    end

    // Tail slot of the pushed level, wrapped into the ring.
    always_comb begin
        tail_sum = (SLOT_BITS+1)'(r_head[i_level])
                 + (SLOT_BITS+1)'(r_count[i_level][SLOT_BITS-1:0]);
        if (tail_sum >= (SLOT_BITS+1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (SLOT_BITS+1)'(QUEUE_DEPTH);
        end
        tail_slot = tail_sum[SLOT_BITS-1:0];
    end

    // Pop picks the lowest-numbered non-empty level.
    always_comb begin
        pop_found = 1'b0;
        pop_level = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                pop_found = 1'b1;
                pop_level = spq_pkg::LEVEL_BITS'(i);
            end
        end
        pop_head = r_head[pop_level];
        if (pop_head == SLOT_BITS'(QUEUE_DEPTH - 1)) begin
            pop_head_next = '0;
        end else begin
            pop_head_next = pop_head + 1'b1;
        end
    end

    // Memory requests for the current beat.
    always_comb begin
        o_wr_en   = i_beat && push_ok;
        o_wr_addr = {i_level, tail_slot};
        o_wr_data = i_word;
        o_rd_en   = i_beat && !is_push && pop_found;
        o_rd_addr = {pop_level, pop_head};
    end

    // Pointer and count updates, plus the result of this beat.
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            n_head[i]  = r_head[i];
            n_count[i] = r_count[i];
        end
        n_result         = '0;
        n_result.valid   = i_beat;
        n_result.status  = spq_pkg::STAT_OK;
        if (i_beat) begin
            if (is_push) begin
                if (push_ok) begin
                    n_count[i_level] = r_count[i_level] + 1'b1;
                    n_result.level   = i_level;
                end else begin
                    n_result.status = spq_pkg::STAT_OVER;
                    n_result.level  = level_ok ? i_level : '0;
                end
            end else if (pop_found) begin
                n_head[pop_level]  = pop_head_next;
                n_count[pop_level] = r_count[pop_level] - 1'b1;
                n_result.level     = pop_level;
                n_result.pop_hit   = 1'b1;
            end else begin
                n_result.status = spq_pkg::STAT_UNDER;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
            r_result <= '0;
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= n_head[i];
                r_count[i] <= n_count[i];
            end
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire
